// File: hdl/pap_pkg.sv
// ----------------------------------------------------------------------------
// pap_pkg: shared types and constants for the polygon area/perimeter unit
// Control structs for the serial arithmetic units, the sequencer states and
// the fixed result widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pap_pkg;

  // Fixed result widths
  localparam int CROSS_BITS = 58;
  localparam int AREA_BITS  = 57;
  localparam int LEN_BITS   = 36;

  // Register select (word address bit 2)
  localparam logic REG_AREA_EN  = 1'b0;
  localparam logic REG_PERIM_EN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_CROSS_ADD,
    ST_CROSS_SUB,
    ST_SQRT,
    ST_LEN,
    ST_EMIT
  } pap_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } pap_mul_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } pap_sqrt_ctl_t;

endpackage

// File: hdl/pap_serial_mult.sv
// ----------------------------------------------------------------------------
// pap_serial_mult: bit-serial signed multiplier
// One multiplier bit per cycle while stepping, shift-right add; the sign bit
// is subtracted on the last step. The product is ready after W steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pap_serial_mult #(
  parameter int W = 25
) (
  input  logic                    clk,
  input  pap_pkg::pap_mul_ctl_t   ctl,
  input  logic [W-1:0]            a,
  input  logic [W-1:0]            b,
  output logic [2*W-1:0]          product
);

  logic [W-1:0] mcand;
  logic [W-1:0] mplier;
  logic [W+1:0] acc_hi;
  logic [W+1:0] ext_a;
  logic [W+1:0] addend;
  logic [W+1:0] sum;

  always_comb begin
    ext_a = {{2{mcand[W-1]}}, mcand};
    if (!mplier[0]) begin
      addend = '0;
    end else if (ctl.last) begin
      addend = -ext_a;
    end else begin
      addend = ext_a;
    end
    sum = acc_hi + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mcand  <= a;
      mplier <= b;
      acc_hi <= '0;
    end else if (ctl.step) begin
      // arithmetic shift of the partial product, low bit into the multiplier
      acc_hi <= {sum[W+1], sum[W+1:1]};
      mplier <= {sum[0], mplier[W-1:1]};
    end
  end

  assign product = {acc_hi[W-1:0], mplier};

endmodule

// File: hdl/pap_serial_sqrt.sv
// ----------------------------------------------------------------------------
// pap_serial_sqrt: restoring integer square root, one root bit per cycle
// Two radicand bits come down each step, while ctl.step is high; the root
// rounds down and is ready after RAD_BITS/2 steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pap_serial_sqrt #(
  parameter int RAD_BITS = 50
) (
  input  logic                         clk,
  input  pap_pkg::pap_sqrt_ctl_t       ctl,
  input  logic [RAD_BITS-1:0]          radicand,
  output logic [RAD_BITS/2-1:0]        root
);

  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int TW        = ROOT_BITS + 3;

  logic [RAD_BITS-1:0]  rad;
  logic [ROOT_BITS:0]   rem;
  logic [TW-1:0]        rem_sh;
  logic [TW-1:0]        trial;
  logic [TW-1:0]        diff;
  logic                 fits;

  always_comb begin
    rem_sh = {rem, rad[RAD_BITS-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (ctl.step) begin
      rad  <= {rad[RAD_BITS-3:0], 2'b00};
      rem  <= fits ? diff[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
      root <= {root[ROOT_BITS-2:0], fits};
    end
  end

endmodule

// File: hdl/polygon_area_perimeter_unit.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_unit: shoelace area and perimeter of one ring
// Accumulates cross terms and rounded-down edge lengths vertex by vertex and
// reports |sum of cross terms| and the length sum on the last vertex.
// ----------------------------------------------------------------------------
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   vertex   | in_valid/in_ready, x_coord, y_coord,     | in
//            | last_vertex                              |
//   result   | out_valid/out_ready, area, perimeter,    | out
//            | overflow                                 |
//   config   | psel/penable/pwrite/paddr/pwdata/prdata  | in/out
//
// An edge runs four serial multipliers side by side and then a serial square
// root, each one bit per cycle. A vertex that adds an edge holds off the next
// transfer until its edge is done; a last vertex runs its edge plus the
// closing edge. A first vertex or one past the vertex limit, when not last,
// is taken without leaving idle. Synchronous reset; the result register lets
// the next vertex in while a result waits, and the unit stalls only when a new
// result finds it full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_area_perimeter_unit #(
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // vertices
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [COORD_BITS-1:0]       x_coord,
  input  logic signed [COORD_BITS-1:0]       y_coord,
  input  logic                               last_vertex,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pap_pkg::AREA_BITS-1:0]      area,
  output logic [pap_pkg::LEN_BITS-1:0]       perimeter,
  output logic                               overflow
);

  localparam int W         = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * W;
  localparam int SUM_BITS  = ((PROD_BITS > pap_pkg::CROSS_BITS) ? PROD_BITS
                              : pap_pkg::CROSS_BITS) + 1;
  localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
  localparam int STEP_BITS = $clog2(W);
  localparam int CB        = pap_pkg::CROSS_BITS;
  localparam int LB        = pap_pkg::LEN_BITS;
  localparam int AB        = pap_pkg::AREA_BITS;

  localparam logic signed [SUM_BITS-1:0] CROSS_HI =
    {{(SUM_BITS-AB){1'b0}}, {AB{1'b1}}};
  localparam logic signed [SUM_BITS-1:0] CROSS_LO = ~CROSS_HI;

  pap_pkg::pap_state_t    state, state_next;
  pap_pkg::pap_mul_ctl_t  mul_ctl;
  pap_pkg::pap_sqrt_ctl_t sqrt_ctl;

  logic                   area_en, perim_en;
  logic                   cfg_write;

  logic [COORD_BITS-1:0]  first_x, first_y, prev_x, prev_y;
  logic [COORD_BITS-1:0]  ax, ay, bx, by;
  logic signed [CB-1:0]   cross_sum;
  logic [LB-1:0]          length_sum;
  logic [CNT_BITS-1:0]    vertex_count;
  logic                   in_polygon;
  logic                   saturated;
  logic                   close_pend;
  logic                   emit_pend;
  logic [STEP_BITS-1:0]   step_cnt;
  logic                   step_last;

  logic                   in_xfer;
  logic                   has_room;
  logic                   out_free;

  logic [W-1:0]           ax_w, ay_w, bx_w, by_w, dx, dy;
  logic [PROD_BITS-1:0]   prod [4];
  logic [PROD_BITS-1:0]   radicand;
  logic [W-1:0]           root;

  logic signed [SUM_BITS-1:0] cross_ext, addend, cross_raw;
  logic signed [CB-1:0]       cross_clamped;
  logic                       cross_over;
  logic [LB:0]                len_raw;
  logic [CB-1:0]              area_mag;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_en  <= 1'b1;
      perim_en <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[2])
        pap_pkg::REG_AREA_EN:  area_en  <= pwdata[0];
        pap_pkg::REG_PERIM_EN: perim_en <= pwdata[0];
        default:               area_en  <= area_en;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pap_pkg::REG_AREA_EN:  prdata = {31'b0, area_en};
      pap_pkg::REG_PERIM_EN: prdata = {31'b0, perim_en};
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Serial arithmetic units
  // --------------------------------------------------------------------------
  assign ax_w = {ax[COORD_BITS-1], ax};
  assign ay_w = {ay[COORD_BITS-1], ay};
  assign bx_w = {bx[COORD_BITS-1], bx};
  assign by_w = {by[COORD_BITS-1], by};
  assign dx   = bx_w - ax_w;
  assign dy   = by_w - ay_w;

  pap_serial_mult #(.W(W)) u_mul_axby (
    .clk(clk), .ctl(mul_ctl), .a(ax_w), .b(by_w), .product(prod[0]));
  pap_serial_mult #(.W(W)) u_mul_bxay (
    .clk(clk), .ctl(mul_ctl), .a(bx_w), .b(ay_w), .product(prod[1]));
  pap_serial_mult #(.W(W)) u_mul_dxdx (
    .clk(clk), .ctl(mul_ctl), .a(dx), .b(dx), .product(prod[2]));
  pap_serial_mult #(.W(W)) u_mul_dydy (
    .clk(clk), .ctl(mul_ctl), .a(dy), .b(dy), .product(prod[3]));

  assign radicand = prod[2] + prod[3];

  pap_serial_sqrt #(.RAD_BITS(PROD_BITS)) u_sqrt (
    .clk(clk), .ctl(sqrt_ctl), .radicand(radicand), .root(root));

  // --------------------------------------------------------------------------
  // Accumulator arithmetic
  // --------------------------------------------------------------------------
  always_comb begin
    cross_ext = {{(SUM_BITS-CB){cross_sum[CB-1]}}, cross_sum};
    if (state == pap_pkg::ST_CROSS_ADD) begin
      addend = {{(SUM_BITS-PROD_BITS){prod[0][PROD_BITS-1]}}, prod[0]};
    end else begin
      addend = -{{(SUM_BITS-PROD_BITS){prod[1][PROD_BITS-1]}}, prod[1]};
    end
    cross_raw = cross_ext + addend;
    if (cross_raw > CROSS_HI) begin
      cross_clamped = CROSS_HI[CB-1:0];
      cross_over    = 1'b1;
    end else if (cross_raw < CROSS_LO) begin
      cross_clamped = CROSS_LO[CB-1:0];
      cross_over    = 1'b1;
    end else begin
      cross_clamped = cross_raw[CB-1:0];
      cross_over    = 1'b0;
    end
    len_raw  = {1'b0, length_sum} + {{(LB+1-W){1'b0}}, root};
    area_mag = cross_sum[CB-1] ? -cross_sum : cross_sum;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_xfer   = in_valid && in_ready;
  assign has_room  = (vertex_count < CNT_BITS'(MAX_VERTICES));
  assign out_free  = !out_valid || out_ready;
  assign step_last = (step_cnt == STEP_BITS'(W - 1));

  always_comb begin
    state_next = state;
    case (state)
      pap_pkg::ST_IDLE: begin
        if (in_valid && ((in_polygon && has_room) || last_vertex)) begin
          state_next = pap_pkg::ST_LOAD;
        end
      end
      pap_pkg::ST_LOAD:      state_next = pap_pkg::ST_MUL;
      pap_pkg::ST_MUL: begin
        if (step_last) state_next = pap_pkg::ST_CROSS_ADD;
      end
      pap_pkg::ST_CROSS_ADD: state_next = pap_pkg::ST_CROSS_SUB;
      pap_pkg::ST_CROSS_SUB: state_next = pap_pkg::ST_SQRT;
      pap_pkg::ST_SQRT: begin
        if (step_last) state_next = pap_pkg::ST_LEN;
      end
      pap_pkg::ST_LEN: begin
        if (close_pend) begin
          state_next = pap_pkg::ST_LOAD;
        end else if (emit_pend) begin
          state_next = pap_pkg::ST_EMIT;
        end else begin
          state_next = pap_pkg::ST_IDLE;
        end
      end
      pap_pkg::ST_EMIT: begin
        if (out_free) state_next = pap_pkg::ST_IDLE;
      end
      default: state_next = pap_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mul_ctl       = '0;
    sqrt_ctl      = '0;
    mul_ctl.last  = step_last;
    case (state)
      pap_pkg::ST_IDLE:      in_ready      = 1'b1;
      pap_pkg::ST_LOAD:      mul_ctl.load  = 1'b1;
      pap_pkg::ST_MUL:       mul_ctl.step  = 1'b1;
      pap_pkg::ST_CROSS_ADD: sqrt_ctl.load = 1'b1;
      pap_pkg::ST_SQRT:      sqrt_ctl.step = 1'b1;
      default:               in_ready      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pap_pkg::ST_LOAD || state == pap_pkg::ST_CROSS_SUB) begin
      step_cnt <= '0;
    end else if (state == pap_pkg::ST_MUL || state == pap_pkg::ST_SQRT) begin
      step_cnt <= step_cnt + STEP_BITS'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Polygon state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x      <= '0;
      first_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      cross_sum    <= '0;
      length_sum   <= '0;
      vertex_count <= '0;
      in_polygon   <= 1'b0;
      saturated    <= 1'b0;
      close_pend   <= 1'b0;
      emit_pend    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != pap_pkg::ST_EMIT) out_valid <= 1'b0;

      case (state)
        pap_pkg::ST_IDLE: begin
          if (in_xfer) begin
            emit_pend <= last_vertex;
            if (!in_polygon) begin
              // open a new ring; a lone last vertex closes onto itself
              first_x      <= x_coord;
              first_y      <= y_coord;
              prev_x       <= x_coord;
              prev_y       <= y_coord;
              ax           <= x_coord;
              ay           <= y_coord;
              bx           <= x_coord;
              by           <= y_coord;
              cross_sum    <= '0;
              length_sum   <= '0;
              vertex_count <= CNT_BITS'(1);
              saturated    <= 1'b0;
              in_polygon   <= 1'b1;
              close_pend   <= 1'b0;
            end else if (has_room) begin
              ax           <= prev_x;
              ay           <= prev_y;
              bx           <= x_coord;
              by           <= y_coord;
              prev_x       <= x_coord;
              prev_y       <= y_coord;
              vertex_count <= vertex_count + CNT_BITS'(1);
              close_pend   <= last_vertex;
            end else begin
              // drop the vertex, close from the last one kept
              saturated  <= 1'b1;
              ax         <= prev_x;
              ay         <= prev_y;
              bx         <= first_x;
              by         <= first_y;
              close_pend <= 1'b0;
            end
          end
        end
        pap_pkg::ST_CROSS_ADD, pap_pkg::ST_CROSS_SUB: begin
          cross_sum <= cross_clamped;
          if (cross_over) saturated <= 1'b1;
        end
        pap_pkg::ST_LEN: begin
          if (len_raw[LB]) begin
            length_sum <= {LB{1'b1}};
            saturated  <= 1'b1;
          end else begin
            length_sum <= len_raw[LB-1:0];
          end
          if (close_pend) begin
            ax         <= prev_x;
            ay         <= prev_y;
            bx         <= first_x;
            by         <= first_y;
            close_pend <= 1'b0;
          end
        end
        pap_pkg::ST_EMIT: begin
          if (out_free) begin
            area         <= area_en ? (area_mag[CB-1] ? {AB{1'b1}} : area_mag[AB-1:0])
                                    : '0;
            perimeter    <= perim_en ? length_sum : '0;
            overflow     <= saturated || area_mag[CB-1];
            out_valid    <= 1'b1;
            emit_pend    <= 1'b0;
            in_polygon   <= 1'b0;
            vertex_count <= '0;
            cross_sum    <= '0;
            length_sum   <= '0;
            saturated    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_BITS'(MAX_VERTICES))
    else $error("vertex count past limit");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == pap_pkg::ST_IDLE && !in_polygon) |->
      (cross_sum == '0 && length_sum == '0 && !saturated))
    else $error("accumulators not cleared between rings");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == pap_pkg::ST_EMIT && out_free) |=>
      (out_valid && state == pap_pkg::ST_IDLE && !in_polygon))
    else $error("result not registered on emit");

  a_len_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state == pap_pkg::ST_LEN) |=> (length_sum >= $past(length_sum)))
    else $error("length sum decreased");

  a_close_then_emit: assert property (@(posedge clk) disable iff (rst)
    close_pend |-> emit_pend)
    else $error("closing edge pending without a result");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: polygon_area_perimeter_unit checker
// Drives vertex rings through the valid/ready input with random gaps, stalls
// the result side at random, and compares every result field against an
// in-bench shoelace/edge-length tracker. Covers directed shapes, the enable
// registers (including a change mid-ring), and a long run of random rings.
// ----------------------------------------------------------------------------

module testbench;

  localparam int COORD_BITS    = 24;
  localparam int MAX_VERTICES  = 1024;
  localparam int RANDOM_ITEMS  = 420;
  localparam int SETTLE_CYCLES = 2 * (2 * COORD_BITS + 7) + 20;
  localparam int CYCLE_LIMIT   = 3000000;

  localparam longint CROSS_HI = (longint'(1) <<< (pap_pkg::CROSS_BITS - 1)) - 1;
  localparam longint CROSS_LO = -CROSS_HI - 1;
  localparam longint unsigned AREA_HI = (64'd1 << pap_pkg::AREA_BITS) - 1;
  localparam longint unsigned LEN_HI  = (64'd1 << pap_pkg::LEN_BITS) - 1;

  localparam logic [2:0] ADDR_AREA_EN  = {pap_pkg::REG_AREA_EN, 2'b00};
  localparam logic [2:0] ADDR_PERIM_EN = {pap_pkg::REG_PERIM_EN, 2'b00};

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic [pap_pkg::AREA_BITS-1:0] area;
    logic [pap_pkg::LEN_BITS-1:0]  perimeter;
    logic                          overflow;
  } ring_result_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [2:0]                    paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_ready;
  coord_t                        x_coord;
  coord_t                        y_coord;
  logic                          last_vertex;
  logic                          out_valid;
  logic                          out_ready;
  logic [pap_pkg::AREA_BITS-1:0] area;
  logic [pap_pkg::LEN_BITS-1:0]  perimeter;
  logic                          overflow;

  polygon_area_perimeter_unit #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .last_vertex(last_vertex),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .area       (area),
    .perimeter  (perimeter),
    .overflow   (overflow)
  );

  always #10 clk = ~clk;

  // Tracker state for the ring in progress
  bit             area_on;
  bit             perim_on;
  coord_t         ring_first_x, ring_first_y, ring_prev_x, ring_prev_y;
  longint         cross_acc;
  longint unsigned perim_acc;
  int unsigned    ring_vertices;
  bit             ring_open;
  bit             ring_saturated;

  ring_result_t   expected_rings[$];
  int unsigned    mismatches;
  int unsigned    cycle_count;
  bit             tx_steady;
  bit             rx_steady;
  int unsigned    stall_left;

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0d (0x%0h), got %0d (0x%0h)",
               what, want, want, got, got);
  endtask

  function automatic longint clamp_cross(input longint s);
    if (s > CROSS_HI) begin
      ring_saturated = 1'b1;
      return CROSS_HI;
    end
    if (s < CROSS_LO) begin
      ring_saturated = 1'b1;
      return CROSS_LO;
    end
    return s;
  endfunction

  // Squared edge length stays below 2^49, so the root fits in 25 bits.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v)
        root = trial;
    end
    return root;
  endfunction

  function automatic void add_edge(input longint ax, input longint ay,
                                   input longint bx, input longint by);
    longint          dx;
    longint          dy;
    longint unsigned len_sq;
    cross_acc = clamp_cross(cross_acc + ax * by);
    cross_acc = clamp_cross(cross_acc - bx * ay);
    dx = bx - ax;
    dy = by - ay;
    len_sq = longint'(dx * dx) + longint'(dy * dy);
    perim_acc += floor_sqrt(len_sq);
    if (perim_acc > LEN_HI) begin
      perim_acc = LEN_HI;
      ring_saturated = 1'b1;
    end
  endfunction

  // Advance the ring by one transferred vertex; queue a result on the last.
  function automatic void track_vertex(input coord_t x, input coord_t y,
                                       input logic last);
    longint unsigned mag;
    ring_result_t    res;
    if (!ring_open) begin
      ring_first_x   = x;
      ring_first_y   = y;
      ring_prev_x    = x;
      ring_prev_y    = y;
      cross_acc      = 0;
      perim_acc      = 0;
      ring_vertices  = 1;
      ring_saturated = 1'b0;
      ring_open      = 1'b1;
    end else if (ring_vertices < MAX_VERTICES) begin
      add_edge(longint'(ring_prev_x), longint'(ring_prev_y), longint'(x), longint'(y));
      ring_prev_x = x;
      ring_prev_y = y;
      ring_vertices++;
    end else begin
      ring_saturated = 1'b1;
    end
    if (!last)
      return;
    add_edge(longint'(ring_prev_x), longint'(ring_prev_y),
             longint'(ring_first_x), longint'(ring_first_y));
    mag = (cross_acc < 0) ? longint'(-cross_acc) : longint'(cross_acc);
    if (mag > AREA_HI) begin
      mag = AREA_HI;
      ring_saturated = 1'b1;
    end
    res.area      = area_on ? mag[pap_pkg::AREA_BITS-1:0] : '0;
    res.perimeter = perim_on ? perim_acc[pap_pkg::LEN_BITS-1:0] : '0;
    res.overflow  = ring_saturated;
    expected_rings.push_back(res);
    ring_open      = 1'b0;
    ring_vertices  = 0;
    cross_acc      = 0;
    perim_acc      = 0;
    ring_saturated = 1'b0;
  endfunction

  // Check results first, then fold in the vertex taken at the same edge.
  always @(posedge clk) begin : watch_rings
    ring_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rings.size() == 0) begin
          note_mismatch("result with nothing pending (area)", '0, 64'(area));
        end else begin
          want = expected_rings.pop_front();
          if (area !== want.area)
            note_mismatch("area", 64'(want.area), 64'(area));
          if (perimeter !== want.perimeter)
            note_mismatch("perimeter", 64'(want.perimeter), 64'(perimeter));
          if (overflow !== want.overflow)
            note_mismatch("overflow", 64'(want.overflow), 64'(overflow));
        end
      end
      if (in_valid && in_ready)
        track_vertex(x_coord, y_coord, last_vertex);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side back-pressure
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_steady && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic coord_t pick_coord();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)
      return COORD_MIN;
    if (roll < 16)
      return COORD_MAX;
    if (roll < 20)
      return '0;
    if (roll < 45)
      return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    return coord_t'($urandom());
  endfunction

  task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
    int unsigned gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    x_coord     <= x;
    y_coord     <= y;
    last_vertex <= last;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_rings.size() != 0)
      @(posedge clk);
  endtask

  // Also covers a non-last vertex whose edge is still in flight.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic [2:0] addr, input bit write,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    rdata = prdata;
    if (write) begin
      if (addr[2] == pap_pkg::REG_AREA_EN)
        area_on = wdata[0];
      else
        perim_on = wdata[0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_enables();
    logic [31:0] rdata;
    apb_access(ADDR_AREA_EN, 1'b0, '0, rdata);
    if (rdata !== {31'b0, area_on})
      note_mismatch("area_enable readback", 64'(area_on), 64'(rdata));
    apb_access(ADDR_PERIM_EN, 1'b0, '0, rdata);
    if (rdata !== {31'b0, perim_on})
      note_mismatch("perimeter_enable readback", 64'(perim_on), 64'(rdata));
  endtask

  task automatic set_enables(input bit area_bit, input bit perim_bit);
    logic [31:0] rdata;
    apb_access(ADDR_AREA_EN, 1'b1, {31'b0, area_bit}, rdata);
    apb_access(ADDR_PERIM_EN, 1'b1, {31'b0, perim_bit}, rdata);
    check_enables();
  endtask

  task automatic send_random_triangle();
    send_vertex(pick_coord(), pick_coord(), 1'b0);
    send_vertex(pick_coord(), pick_coord(), 1'b0);
    send_vertex(pick_coord(), pick_coord(), 1'b1);
  endtask

  task automatic test_directed_shapes();
    // single-vertex rings
    send_vertex('0, '0, 1'b1);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    // square of side 256, counterclockwise
    send_vertex(24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd256, 24'sd0, 1'b0);
    send_vertex(24'sd256, 24'sd256, 1'b0);
    send_vertex(24'sd0, 24'sd256, 1'b1);
    wait_drained();
    // clockwise triangle over the full range
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b1);
    // longest possible edge, out and back
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // collinear points: zero area
    send_vertex(24'sd0, 24'sd0, 1'b0);
    send_vertex(24'sd256, 24'sd256, 1'b0);
    send_vertex(-24'sd512, -24'sd512, 1'b1);
    // all-ones coordinates, with one zero
    send_vertex(-24'sd1, -24'sd1, 1'b0);
    send_vertex(-24'sd1, 24'sd0, 1'b1);
  endtask

  task automatic test_register_settings();
    wait_idle();
    check_enables();
    set_enables(1'b0, 1'b1);
    send_random_triangle();
    wait_idle();
    set_enables(1'b1, 1'b0);
    send_random_triangle();
    wait_idle();
    set_enables(1'b0, 1'b0);
    send_random_triangle();
    // change the enables while a ring is open
    send_vertex(COORD_MIN, 24'sd1000, 1'b0);
    send_vertex(24'sd4000, COORD_MAX, 1'b0);
    wait_idle();
    set_enables(1'b1, 1'b1);
    send_vertex(24'sd77, -24'sd9000, 1'b1);
    wait_idle();
    set_enables(1'b1, 1'b1);
  endtask

  function automatic int unsigned pick_ring_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8)
      return 1;
    if (roll < 18)
      return 2;
    if (roll < 85)
      return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  task automatic test_random_rings();
    int unsigned sent;
    int unsigned next_phase;
    int unsigned ring_len;
    sent       = 0;
    next_phase = 90;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_phase) begin
        wait_idle();
        set_enables(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        tx_steady  = ($urandom_range(0, 3) == 0);
        rx_steady  = ($urandom_range(0, 3) == 0);
        next_phase += 90;
      end
      ring_len = pick_ring_len();
      for (int unsigned i = 0; i < ring_len; i++) begin
        send_vertex(pick_coord(), pick_coord(), i == ring_len - 1);
        sent++;
      end
      if ($urandom_range(0, 9) == 0)
        wait_drained();
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    x_coord        = '0;
    y_coord        = '0;
    last_vertex    = 1'b0;
    out_ready      = 1'b0;
    stall_left     = 0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    area_on        = 1'b1;
    perim_on       = 1'b1;
    ring_first_x   = '0;
    ring_first_y   = '0;
    ring_prev_x    = '0;
    ring_prev_y    = '0;
    cross_acc      = 0;
    perim_acc      = 0;
    ring_vertices  = 0;
    ring_open      = 1'b0;
    ring_saturated = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_shapes();
    test_register_settings();
    test_random_rings();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: files.f
hdl/pap_pkg.sv
hdl/pap_serial_mult.sv
hdl/pap_serial_sqrt.sv
hdl/polygon_area_perimeter_unit.sv
dv/testbench.sv
